// ===== design/cfq_pkg.sv =====
// Shared types and codes for the circular FIFO queue.
// No dependencies; imported by circular_fifo_queue.
package cfq_pkg;

    localparam int CFQ_DEPTH = 8;
    localparam int CFQ_PTR_W = $clog2(CFQ_DEPTH);
    localparam int CFQ_WORD_W = 32;

    typedef logic [1:0] t_action;
    typedef logic [1:0] t_status;
    typedef logic signed [CFQ_WORD_W-1:0] t_word;
    typedef logic [CFQ_PTR_W-1:0] t_ptr;

    localparam t_action ACT_ENQ = 2'd0;
    localparam t_action ACT_DEQ = 2'd1;
    localparam t_action ACT_DISP = 2'd2;

    localparam t_status ST_OK = 2'd0;
    localparam t_status ST_FULL = 2'd1;
    localparam t_status ST_EMPTY = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_DISP  = 3'b010,
        S_DRAIN = 3'b100
    } t_state;

    function automatic t_ptr ptr_adv(input t_ptr p);
        t_ptr r;
        if (p == t_ptr'(CFQ_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + t_ptr'(1);
        end
        return r;
    endfunction

endpackage

// ===== design/circular_fifo_queue.sv =====
// Top level of the circular FIFO queue: pointers, sequencer and result register.
// Depends on cfq_pkg and cfq_ram.
//
// Usage:
//   Drive i_action and i_push_value and raise start; the command transfers at
//   a rising edge where start is high and busy is low. Action enqueue stores
//   i_push_value at the tail or reports full; dequeue returns the head word or
//   reports empty; display returns every stored word oldest first, o_last
//   marking the final one. Action code 3 transfers but does nothing.
//   Each result is shown for one cycle with o_valid high; the receiver must
//   take it then, it cannot stall the block.
// Timing and throughput:
//   Enqueue and empty/full results are registered and appear in the cycle
//   after the transfer; busy stays low, so one such command per cycle.
//   Dequeue: the head word passes the storage RAM's read register and then
//   the result register; busy stays high until the result is loaded.
//   Display of N words: one word per cycle, busy until the last word is
//   loaded; the walk reads the RAM one entry per cycle.
// Reset:
//   i_rst_n low at a rising edge empties the queue and returns to idle; the
//   storage itself is not cleared.
module circular_fifo_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  cfq_pkg::t_action  i_action,
    input  cfq_pkg::t_word    i_push_value,
    output logic              o_valid,
    output cfq_pkg::t_status  o_status,
    output cfq_pkg::t_word    o_read_value,
    output logic              o_last
);

    import cfq_pkg::*;

    t_state  r_state, n_state;
    t_ptr    r_head, n_head;
    t_ptr    r_tail, n_tail;
    logic    r_empty, n_empty;
    t_ptr    r_walk, n_walk;
    logic    r_pend, n_pend;
    logic    r_pend_last, n_pend_last;
    logic    r_valid, n_valid;
    t_status r_status, n_status;
    t_word   r_value, n_value;
    logic    r_last, n_last;

    logic    accept;
    logic    full;
    logic    ram_we;
    logic    ram_re;
    t_ptr    ram_raddr;
    t_word   ram_rdata;
    t_ptr    head_nxt;
    t_ptr    walk_nxt;

    assign busy = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign full = !r_empty && (r_head == r_tail);
    assign head_nxt = ptr_adv(r_head);
    assign walk_nxt = ptr_adv(r_walk);

    always_comb begin
        n_state = r_state;
        n_head = r_head;
        n_tail = r_tail;
        n_empty = r_empty;
        n_walk = r_walk;
        n_pend = 1'b0;
        n_pend_last = r_pend_last;
        n_valid = 1'b0;
        n_status = r_status;
        n_value = r_value;
        n_last = r_last;
        ram_we = 1'b0;
        ram_re = 1'b0;
        ram_raddr = r_head;

        if (r_pend) begin
            n_valid = 1'b1;
            n_status = ST_OK;
            n_value = ram_rdata;
            n_last = r_pend_last;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_action)
                        ACT_ENQ: begin
                            n_valid = 1'b1;
                            n_value = '0;
                            n_last = 1'b1;
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                ram_we = 1'b1;
                                n_tail = ptr_adv(r_tail);
                                n_empty = 1'b0;
                                n_status = ST_OK;
                            end
                        end
                        ACT_DEQ: begin
                            if (r_empty) begin
                                n_valid = 1'b1;
                                n_status = ST_EMPTY;
                                n_value = '0;
                                n_last = 1'b1;
                            end else begin
                                ram_re = 1'b1;
                                n_pend = 1'b1;
                                n_pend_last = 1'b1;
                                n_head = head_nxt;
                                n_empty = (head_nxt == r_tail);
                                n_state = S_DRAIN;
                            end
                        end
                        ACT_DISP: begin
                            if (r_empty) begin
                                n_valid = 1'b1;
                                n_status = ST_EMPTY;
                                n_value = '0;
                                n_last = 1'b1;
                            end else begin
                                ram_re = 1'b1;
                                n_pend = 1'b1;
                                n_pend_last = (head_nxt == r_tail);
                                n_walk = head_nxt;
                                n_state = (head_nxt == r_tail) ? S_DRAIN : S_DISP;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DISP: begin
                ram_re = 1'b1;
                ram_raddr = r_walk;
                n_pend = 1'b1;
                n_pend_last = (walk_nxt == r_tail);
                n_walk = walk_nxt;
                if (walk_nxt == r_tail) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head <= '0;
            r_tail <= '0;
            r_empty <= 1'b1;
            r_pend <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head <= n_head;
            r_tail <= n_tail;
            r_empty <= n_empty;
            r_pend <= n_pend;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_walk <= n_walk;
        r_pend_last <= n_pend_last;
        r_status <= n_status;
        r_value <= n_value;
        r_last <= n_last;
    end

    cfq_ram #(
        .DEPTH(CFQ_DEPTH),
        .WIDTH(CFQ_WORD_W),
        .AW(CFQ_PTR_W)
    ) u_ram (
        .i_clk(i_clk),
        .i_we(ram_we),
        .i_waddr(r_tail),
        .i_wdata(i_push_value),
        .i_re(ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign o_valid = r_valid;
    assign o_status = r_status;
    assign o_read_value = r_value;
    assign o_last = r_last;

endmodule

// ===== design/cfq_ram.sv =====
// Simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module cfq_ram #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 32,
    parameter int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
